[rtl/iq4_xs_block_dequantizer_assert.svh]
// Assertion macros for the IQ4_XS block dequantizer.
`ifndef IQ4_XS_BLOCK_DEQUANTIZER_ASSERT_SVH
`define IQ4_XS_BLOCK_DEQUANTIZER_ASSERT_SVH
`ifndef SYNTH
`define IQX_ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IQX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define IQX_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define IQX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/iqx_pkg.sv]
// ----------------------------------------------------------------------------
// IQ4_XS dequantizer package
// Shared constants and types for the block dequantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package iqx_pkg;
  localparam int unsigned ValuesPerSub = 32;
  localparam int unsigned SubBlocks = 8;
  localparam int unsigned ScaleBias = 32;
  localparam logic [31:0] NanCanon = 32'h7FC00000;
  localparam logic [1:0] CfgCb0 = 2'd0;
  localparam logic [1:0] CfgCb1 = 2'd1;
  localparam logic [1:0] CfgCb2 = 2'd2;
  localparam logic [1:0] CfgCb3 = 2'd3;
  localparam logic [31:0] CbReset0 = 32'd3215825025;
  localparam logic [31:0] CbReset1 = 32'd4142587343;
  localparam logic [31:0] CbReset2 = 32'd639175937;
  localparam logic [31:0] CbReset3 = 32'd1901675829;

  typedef struct packed {
    logic        start;
    logic [31:0] scale_bits;
    logic [7:0]  factor;
  } mul_req_t;
endpackage

[rtl/iqx_fmul.sv]
// ----------------------------------------------------------------------------
// IQ4_XS scaled multiply
// Multiplies an fp32 value by a signed 8-bit integer with a registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iqx_fmul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iqx_pkg::mul_req_t req_i,
  output logic             done_o,
  output logic [31:0]      result_o
);
  import iqx_pkg::*;

  logic        sgn;
  logic [7:0]  ex;
  logic [23:0] sig;
  logic [7:0]  mag;
  logic [31:0] prod;
  logic [4:0]  lz;
  logic [31:0] norm;
  logic [9:0]  rexp;
  logic [31:0] res_d;
  logic [31:0] res_q;
  logic        done_q;

  always_comb begin
    sgn  = req_i.scale_bits[31] ^ req_i.factor[7];
    ex   = req_i.scale_bits[30:23];
    mag  = req_i.factor[7] ? 8'(-req_i.factor) : req_i.factor;
    sig  = {(ex != 8'd0), req_i.scale_bits[22:0]};
    prod = 32'(sig) * 32'(mag);
    lz   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (prod[i]) lz = 5'(31 - i);
    end
    norm = prod << lz;
    rexp = 10'(ex) + 10'd8 - 10'(lz) + ((ex == 8'd0) ? 10'd1 : 10'd0);
    if (ex == 8'hFF) begin
      if (req_i.scale_bits[22:0] != 23'd0 || mag == 8'd0) res_d = NanCanon;
      else res_d = {sgn, 8'hFF, 23'd0};
    end else if (prod == 32'd0) begin
      res_d = {sgn, 31'd0};
    end else if ($signed(rexp) >= 10'sd255) begin
      res_d = {sgn, 8'hFF, 23'd0};
    end else if ($signed(rexp) <= 10'sd0) begin
      res_d = {sgn, 8'd0, 23'(norm[31:8] >> (10'd1 - rexp))};
    end else begin
      res_d = {sgn, rexp[7:0], norm[30:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) res_q <= res_d;
  end

  assign done_o = done_q;
  assign result_o = res_q;
endmodule

[rtl/iq4_xs_block_dequantizer.sv]
// ----------------------------------------------------------------------------
// IQ4_XS block dequantizer
// A data transaction first forms the scale product (states StMul, StWait), then
// passes each value through the shared multiplier (StMul, StWait, StOut); input
// stalls until its last value is taken. A header is taken while idle and leaves
// the block idle.
// Reset clears the scales and the sub-block counter and loads the default codebook.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iq4_xs_block_dequantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind_i,
  input  logic [15:0] scale_half_i,
  input  logic [15:0] scales_high_i,
  input  logic [31:0] scales_low_i,
  input  logic [63:0] quant_lo_i,
  input  logic [63:0] quant_hi_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] weight_value_o,
  output logic        last_o,
  output logic        block_end_o
);
  import iqx_pkg::*;
  `include "iq4_xs_block_dequantizer_assert.svh"

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [31:0]  cb_q [4];
  logic [15:0]  bscale_q;
  logic [15:0]  shigh_q;
  logic [31:0]  slow_q;
  logic [2:0]   sub_q;
  logic [127:0] quant_q;
  logic [4:0]   k_q;
  logic [31:0]  dl_q;
  logic         dl_ok_q;
  logic         endf_q;
  logic [31:0]  d32;
  logic [5:0]   ls;
  logic [7:0]   cbyte;
  logic [3:0]   nib;
  logic [3:0]   jb;
  mul_req_t     req;
  logic         mdone;
  logic [31:0]  mres;
  logic         acc;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_q != StIdle);
  assign cfg_ready = (state_q == StIdle);

  always_comb begin
    logic [4:0] e;
    logic [9:0] m;
    logic [4:0] sh;
    e = bscale_q[14:10];
    m = bscale_q[9:0];
    sh = 5'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) sh = 5'(10 - i);
    end
    if (e == 5'd0) begin
      if (m == 10'd0) d32 = {bscale_q[15], 31'd0};
      else d32 = {bscale_q[15], 8'd113 - 8'(sh), 10'(m << sh), 13'd0};
    end else if (e == 5'd31) begin
      d32 = {bscale_q[15], 8'hFF, m, 13'd0};
    end else begin
      d32 = {bscale_q[15], 8'(e) + 8'd112, m, 13'd0};
    end
  end

  assign ls = {shigh_q[2*sub_q +: 2], slow_q[4*sub_q +: 4]};
  assign jb = k_q[3:0];
  assign cbyte = quant_q[8*jb +: 8];
  assign nib = k_q[4] ? cbyte[7:4] : cbyte[3:0];

  always_comb begin
    logic [7:0] ce;
    ce = cb_q[nib[3:2]][8*nib[1:0] +: 8];
    req.start = (state_q == StMul);
    if (!dl_ok_q) begin
      req.scale_bits = d32;
      req.factor = {2'b00, ls} - 8'(ScaleBias);
    end else begin
      req.scale_bits = dl_q;
      req.factor = ce;
    end
  end

  iqx_fmul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .done_o  (mdone),
    .result_o(mres)
  );

  logic [31:0] big_q;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc && kind_i) state_d = StMul;
      StMul:  state_d = StWait;
      StWait: state_d = dl_ok_q ? StOut : StMul;
      StOut:  if (!out_stall) state_d = (k_q == 5'(ValuesPerSub - 1)) ? StIdle : StMul;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cb_q[0] <= CbReset0;
      cb_q[1] <= CbReset1;
      cb_q[2] <= CbReset2;
      cb_q[3] <= CbReset3;
      bscale_q <= 16'd0;
      shigh_q <= 16'd0;
      slow_q <= 32'd0;
      sub_q <= 3'd0;
      k_q <= 5'd0;
      dl_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) cb_q[cfg_index_i] <= cfg_data_i;
      if (acc && !kind_i) begin
        bscale_q <= scale_half_i;
        shigh_q <= scales_high_i;
        slow_q <= scales_low_i;
        sub_q <= 3'd0;
      end
      if (acc && kind_i) begin
        k_q <= 5'd0;
        dl_ok_q <= 1'b0;
      end
      if (state_q == StWait && !dl_ok_q) dl_ok_q <= 1'b1;
      if (state_q == StOut && !out_stall) begin
        k_q <= k_q + 5'd1;
        if (k_q == 5'(ValuesPerSub - 1)) sub_q <= sub_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && kind_i) begin
      quant_q <= {quant_hi_i, quant_lo_i};
      endf_q <= 1'b0;
    end
    if (state_q == StWait && !dl_ok_q) begin
      dl_q <= mres;
      endf_q <= (sub_q == 3'(SubBlocks - 1));
    end
    if (state_q == StWait && dl_ok_q) big_q <= mres;
  end

  assign out_valid = (state_q == StOut);
  assign weight_value_o = big_q;
  assign last_o = (k_q == 5'(ValuesPerSub - 1));
  assign block_end_o = endf_q;

  `IQX_ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, (out_valid |-> in_stall), "input taken while busy")
  `IQX_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(big_q), "output changed")
  `IQX_ASSERT_NEXT(a_mul_done, clk_i, rst_ni, state_q == StMul, mdone, "multiplier lost")
endmodule

[dv/tb_iq4_xs_block_dequantizer.sv]
// ----------------------------------------------------------------------------
// IQ4_XS block dequantizer testbench
// Drives header and sub-block transactions, predicts every fp32 weight with an
// exact integer model of the scaled codebook product or a given word, and checks
// each output transaction in order under random stalls and codebook settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_iq4_xs_block_dequantizer;
  import iqx_pkg::*;

  localparam logic KindHeader = 1'b0;
  localparam logic KindData = 1'b1;
  localparam int unsigned LongHold = 400;
  localparam int unsigned WatchdogLimit = 3000;

  typedef struct {
    logic        kind;
    logic [15:0] scale;
    logic [15:0] sc_high;
    logic [31:0] sc_low;
    logic [63:0] q_lo;
    logic [63:0] q_hi;
    logic        word_known;
    logic [31:0] word;
  } item_t;

  typedef struct {
    logic [31:0] weight;
    logic        last;
    logic        blk_end;
  } weight_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind_i = 1'b0;
  logic [15:0] scale_half_i = '0;
  logic [15:0] scales_high_i = '0;
  logic [31:0] scales_low_i = '0;
  logic [63:0] quant_lo_i = '0;
  logic [63:0] quant_hi_i = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] weight_value_o;
  logic        last_o;
  logic        block_end_o;

  logic        word_known = 1'b0;
  logic [31:0] known_word = '0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;

  logic [31:0] cb_regs [4];
  logic [15:0] pr_scale;
  logic [15:0] pr_high;
  logic [31:0] pr_low;
  logic [2:0]  pr_index;
  weight_t     weight_q [$];
  item_t       dir_rows [$];
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;

  iq4_xs_block_dequantizer DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] scaled_weight(logic [15:0] h, int a, int c);
    logic        s;
    logic [31:0] prod;
    int          e;
    int          p;
    logic [31:0] shifted;
    s = h[15] ^ (a < 0) ^ (c < 0);
    if (h[14:10] == 5'd31) begin
      if (h[9:0] != 0 || a == 0 || c == 0) return NanCanon;
      return {s, 8'hFF, 23'd0};
    end
    if (h[14:10] == 5'd0) begin
      prod = {22'd0, h[9:0]};
      e = -24;
    end else begin
      prod = {21'd0, 1'b1, h[9:0]};
      e = int'(h[14:10]) - 25;
    end
    prod = prod * (a < 0 ? -a : a) * (c < 0 ? -c : c);
    if (prod == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 32; i++) if (prod[i]) p = i;
    shifted = prod << (23 - p);
    return {s, 8'(p + e + 127), shifted[22:0]};
  endfunction

  function automatic int codebook_value(logic [3:0] nib);
    logic [7:0] b;
    b = cb_regs[nib[3:2]][8 * nib[1:0] +: 8];
    return int'($signed(b));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_scale <= '0;
      pr_high <= '0;
      pr_low <= '0;
      pr_index <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        if (kind_i == KindHeader) begin
          pr_scale <= scale_half_i;
          pr_high <= scales_high_i;
          pr_low <= scales_low_i;
          pr_index <= '0;
        end else begin
          int     a;
          logic [7:0] qb;
          weight_t r;
          a = int'({pr_high[2 * pr_index +: 2], pr_low[4 * pr_index +: 4]}) - int'(ScaleBias);
          for (int k = 0; k < 32; k++) begin
            qb = (k % 16 < 8) ? quant_lo_i[8 * (k % 8) +: 8] : quant_hi_i[8 * (k % 8) +: 8];
            r.weight = scaled_weight(pr_scale, a,
                                     codebook_value(k < 16 ? qb[3:0] : qb[7:4]));
            if (word_known) r.weight = known_word;
            r.last = (k == 31);
            r.blk_end = (pr_index == 3'd7);
            weight_q.push_back(r);
          end
          pr_index <= pr_index + 3'd1;
        end
      end
      if (out_valid && !out_stall) begin
        weight_t x;
        idle_cycles = 0;
        if (weight_q.size() == 0) begin
          $display("%t unexpected weight %h", $time, weight_value_o);
          err_count++;
        end else begin
          x = weight_q.pop_front();
          if (x.weight !== weight_value_o || x.last !== last_o || x.blk_end !== block_end_o) begin
            $display("%t mismatch: expected %h/%b/%b actual %h/%b/%b", $time, x.weight,
                     x.last, x.blk_end, weight_value_o, last_o, block_end_o);
            err_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) idle_cycles = 0;
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LongHold) @(negedge clk_i);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    kind_i = it.kind;
    scale_half_i = it.scale;
    scales_high_i = it.sc_high;
    scales_low_i = it.sc_low;
    quant_lo_i = it.q_lo;
    quant_hi_i = it.q_hi;
    word_known = it.word_known;
    known_word = it.word;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (weight_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_codebook(logic [1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    cb_regs[idx] = data;
  endtask

  task automatic add_row(logic kind, logic [15:0] scale, logic [15:0] sh, logic [31:0] sl,
                         logic [63:0] qlo, logic [63:0] qhi, logic known, logic [31:0] w);
    item_t it;
    it = '{kind, scale, sh, sl, qlo, qhi, known, w};
    dir_rows.push_back(it);
  endtask

  function automatic logic [15:0] random_scale();
    unique case ($urandom_range(0, 11))
      0: return 16'(16'h7C00 | ($urandom_range(0, 1) << 15));
      1: return 16'(16'h7E00 | $urandom_range(1, 511));
      2: return 16'(16'h8000 & ($urandom_range(0, 1) << 15));
      3: return 16'($urandom_range(1, 1023) | ($urandom_range(0, 1) << 15));
      4, 5: return 16'($urandom_range(0, 65535));
      default: return {1'($urandom_range(0, 1)), 5'($urandom_range(10, 20)),
                       10'($urandom_range(0, 1023))};
    endcase
  endfunction

  task automatic run_superblocks(int unsigned count);
    item_t it;
    for (int unsigned b = 0; b < count; b++) begin
      it = '{KindHeader, random_scale(), 16'($urandom), $urandom, {$urandom, $urandom},
             {$urandom, $urandom}, 1'b0, 32'd0};
      if ($urandom_range(0, 9) != 0) send_item(it);
      for (int s = 0; s < 8 + ($urandom_range(0, 9) == 0 ? 2 : 0); s++) begin
        it.kind = ($urandom_range(0, 19) == 0) ? KindHeader : KindData;
        it.scale = random_scale();
        it.sc_high = 16'($urandom);
        it.sc_low = $urandom;
        it.q_lo = {$urandom, $urandom};
        it.q_hi = {$urandom, $urandom};
        send_item(it);
      end
    end
  endtask

  initial begin
    cb_regs[0] = CbReset0;
    cb_regs[1] = CbReset1;
    cb_regs[2] = CbReset2;
    cb_regs[3] = CbReset3;
    add_row(KindData, 16'h0, 16'h0, 32'h0, 64'h0, 64'h0, 1'b1, 32'h0);
    add_row(KindHeader, 16'h7E00, 16'h0, 32'h0, 64'h0, 64'h0, 1'b0, 32'h0);
    add_row(KindData, 16'h0, 16'h0, 32'h0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
            1'b1, NanCanon);
    add_row(KindHeader, 16'h7C00, 16'hAAAA, 32'h0, 64'h0, 64'h0, 1'b0, 32'h0);
    add_row(KindData, 16'h0, 16'h0, 32'h0, 64'hFFFFFFFFFFFFFFFF, 64'h0, 1'b1, NanCanon);
    add_row(KindHeader, 16'hFC00, 16'hFFFF, 32'hFFFFFFFF, 64'h0, 64'h0, 1'b0, 32'h0);
    add_row(KindData, 16'h0, 16'h0, 32'h0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
            1'b0, 32'h0);
    add_row(KindHeader, 16'h7BFF, 16'h0, 32'h0, 64'hFFFFFFFFFFFFFFFF, 64'h0, 1'b0, 32'h0);
    add_row(KindData, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
            64'hFFFFFFFFFFFFFFFF, 1'b0, 32'h0);
    add_row(KindHeader, 16'h0001, 16'h5555, 32'h76543210, 64'h0, 64'h0, 1'b0, 32'h0);
    add_row(KindData, 16'h0, 16'h0, 32'h0, 64'h0011223344556677, 64'h8899AABBCCDDEEFF,
            1'b0, 32'h0);
    add_row(KindHeader, 16'h8000, 16'h1B1B, 32'hFEDCBA98, 64'h0, 64'h0, 1'b0, 32'h0);
    add_row(KindData, 16'h0, 16'h0, 32'h0, 64'h1234, 64'h5678, 1'b0, 32'h0);
    add_row(KindHeader, 16'h3C00, 16'hE4E4, 32'h0F1E2D3C, 64'h0, 64'h0, 1'b0, 32'h0);
    for (int s = 0; s < 9; s++)
      add_row(KindData, 16'h0, 16'h0, 32'h0, {2{32'h76543210 + s}}, {2{32'hFEDCBA98 - s}},
              1'b0, 32'h0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain();
    for (int r = 0; r < 4; r++) write_codebook(r[1:0], $urandom);
    run_superblocks(8);

    drain();
    write_codebook(CfgCb0, 32'h80808080);
    write_codebook(CfgCb1, 32'hFFFFFFFF);
    write_codebook(CfgCb2, 32'h00000000);
    write_codebook(CfgCb3, 32'h7F7F7F7F);
    hold_req = 1'b1;
    run_superblocks(5);
    while (weight_q.size() != 0) @(negedge clk_i);
    run_superblocks(5);

    drain();
    for (int r = 0; r < 4; r++) write_codebook(r[1:0], $urandom);
    run_superblocks(6);
    quiet = 1'b1;
    run_superblocks(5);

    drain();
    repeat (60) @(negedge clk_i);
    if (err_count == 0 && weight_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
